### rtl/tbhar_pkg.sv
`default_nettype none

package tbhar_pkg;

    // field widths fixed by the register map and the result format
    localparam int RECT_BITS      = 48;
    localparam int RECT_EXT_BITS  = 64;
    localparam int DELAY_BITS     = 24;
    localparam int REGION_BITS    = 3;
    localparam int KIND_BITS      = 2;
    localparam int STEP_BITS      = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int NUM_RECTS      = 4;

    // parameter defaults
    localparam int COORD_BITS_DEFAULT = 12;
    localparam int TIME_BITS_DEFAULT  = 48;

    typedef logic [REGION_BITS-1:0] region_t;
    typedef logic [KIND_BITS-1:0]   kind_t;
    typedef logic [STEP_BITS-1:0]   step_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam region_t REGION_NONE      = 3'd0;
    localparam region_t REGION_MINUS     = 3'd1;
    localparam region_t REGION_PLUS      = 3'd2;
    localparam region_t REGION_TRANSPORT = 3'd3;
    localparam region_t REGION_TAP       = 3'd4;

    localparam kind_t KIND_NUDGE     = 2'd0;
    localparam kind_t KIND_TRANSPORT = 2'd1;
    localparam kind_t KIND_TAP       = 2'd2;

    localparam step_t STEP_NONE = 2'b00;
    localparam step_t STEP_UP   = 2'b01;
    localparam step_t STEP_DOWN = 2'b11;

    localparam cfg_index_t CFG_MINUS_RECT     = 3'd0;
    localparam cfg_index_t CFG_PLUS_RECT      = 3'd1;
    localparam cfg_index_t CFG_TRANSPORT_RECT = 3'd2;
    localparam cfg_index_t CFG_TAP_RECT       = 3'd3;
    localparam cfg_index_t CFG_HOLD_DELAY     = 3'd4;
    localparam cfg_index_t CFG_REPEAT_INTERVAL = 3'd5;

    localparam logic [RECT_BITS-1:0] MINUS_RECT_RESET     = 48'd2204728443036;
    localparam logic [RECT_BITS-1:0] PLUS_RECT_RESET      = 48'd31616664486044;
    localparam logic [RECT_BITS-1:0] TRANSPORT_RECT_RESET = 48'd2207817203900;
    localparam logic [RECT_BITS-1:0] TAP_RECT_RESET       = 48'd3300148052188;
    localparam logic [DELAY_BITS-1:0] HOLD_DELAY_RESET      = 24'd400000;
    localparam logic [DELAY_BITS-1:0] REPEAT_INTERVAL_RESET = 24'd120000;

endpackage

`default_nettype wire

### rtl/tbhar_rect_hit.sv
`default_nettype none

module tbhar_rect_hit #(
    parameter int COORD_BITS = tbhar_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic [COORD_BITS-1:0]          x,
    input  wire logic [COORD_BITS-1:0]          y,
    input  wire logic [tbhar_pkg::RECT_BITS-1:0] rect,
    output      logic                            hit
);

    logic [tbhar_pkg::RECT_EXT_BITS-1:0] rect_ext;
    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
    logic [COORD_BITS-1:0] rw;
    logic [COORD_BITS-1:0] rh;
    logic [COORD_BITS:0]   x_end;
    logic [COORD_BITS:0]   y_end;

    // fields past the register top read as zero
    assign rect_ext = {{(tbhar_pkg::RECT_EXT_BITS - tbhar_pkg::RECT_BITS){1'b0}}, rect};
    assign rx = rect_ext[COORD_BITS*3 +: COORD_BITS];
    assign ry = rect_ext[COORD_BITS*2 +: COORD_BITS];
    assign rw = rect_ext[COORD_BITS*1 +: COORD_BITS];
    assign rh = rect_ext[0 +: COORD_BITS];

    // one extra bit so the far edge never wraps
    assign x_end = {1'b0, rx} + {1'b0, rw};
    assign y_end = {1'b0, ry} + {1'b0, rh};

    assign hit = (x >= rx) && (y >= ry)
              && ({1'b0, x} < x_end) && ({1'b0, y} < y_end);

endmodule

`default_nettype wire

### rtl/touch_button_hit_auto_repeat.sv
`default_nettype none

// touch poll decoder for four on-screen buttons with minus/plus auto-repeat
// input channel (s_*): one touch poll per transaction, fields in s_tdata
// output channel (m_*): exactly one result transaction for every poll taken
// config port: cfg_we writes cfg_data into register cfg_index at the clock
//   edge; indexes 0..3 are the button rectangles, 4 the hold delay, 5 the
//   repeat interval; other indexes are ignored; write only while idle
// path: a poll accepted into the input register moves on to the result
//   register, which drives m_*, whenever the result register is free
// throughput: one poll per cycle while m_tready stays high; the only loop
//   is held-touch state, updated in the same cycle as the result register
// the result register and the input register each hold one transaction,
//   so while a result waits s_tready stays high until the input register
//   holds a transaction as well
// when the receiver stalls, the result holds, the input register fills and
//   then s_tready drops; nothing is lost or repeated
// reset: both registers empty, touch released, no held button, both
//   timestamps zero, all config registers back to their power-on values

module touch_button_hit_auto_repeat #(
    parameter int COORD_BITS = tbhar_pkg::COORD_BITS_DEFAULT,
    parameter int TIME_BITS  = tbhar_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // touch_down, touch_x, touch_y, time_us (zero padding above)
    input  wire logic [((1 + 2*COORD_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,

    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // region, command_valid, nudge_step (zero padding above)
    output      logic [7:0]            m_tdata,
    // command_kind
    output      logic [tbhar_pkg::KIND_BITS-1:0] m_tuser,

    input  wire logic                               cfg_we,
    input  wire logic [tbhar_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [tbhar_pkg::RECT_BITS-1:0]    cfg_data
);

    localparam int OUT_BITS = tbhar_pkg::REGION_BITS + 1 + tbhar_pkg::STEP_BITS;
    localparam int X_LSB    = 1;
    localparam int Y_LSB    = 1 + COORD_BITS;
    localparam int T_LSB    = 1 + 2*COORD_BITS;

    // configuration
    logic [tbhar_pkg::RECT_BITS-1:0]  rect_reg [tbhar_pkg::NUM_RECTS];
    logic [tbhar_pkg::DELAY_BITS-1:0] hold_delay_reg;
    logic [tbhar_pkg::DELAY_BITS-1:0] repeat_interval_reg;

    // input register
    logic                  in_valid_reg;
    logic                  in_down_reg;
    logic [COORD_BITS-1:0] in_x_reg;
    logic [COORD_BITS-1:0] in_y_reg;
    logic [TIME_BITS-1:0]  in_time_reg;

    // held-touch state
    logic                  was_pressed_reg;
    logic                  was_pressed_next;
    tbhar_pkg::region_t    held_region_reg;
    tbhar_pkg::region_t    held_region_next;
    logic [TIME_BITS-1:0]  press_time_reg;
    logic [TIME_BITS-1:0]  press_time_next;
    logic [TIME_BITS-1:0]  last_fire_time_reg;
    logic [TIME_BITS-1:0]  last_fire_time_next;

    // result register
    logic                  out_valid_reg;
    tbhar_pkg::region_t    out_region_reg;
    tbhar_pkg::region_t    out_region_next;
    logic                  out_cmd_valid_reg;
    logic                  out_cmd_valid_next;
    tbhar_pkg::kind_t      out_kind_reg;
    tbhar_pkg::kind_t      out_kind_next;
    tbhar_pkg::step_t      out_step_reg;
    tbhar_pkg::step_t      out_step_next;

    logic                  advance;
    logic                  out_free;
    logic [tbhar_pkg::NUM_RECTS-1:0] hits;
    tbhar_pkg::region_t    hit_region;
    logic                  fire;
    logic [TIME_BITS-1:0]  since_press;
    logic [TIME_BITS-1:0]  since_fire;
    logic [TIME_BITS-1:0]  hold_delay_ext;
    logic [TIME_BITS-1:0]  repeat_interval_ext;
    logic                  repeat_due;

    // handshake: the input slot drains whenever the result slot is free
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - OUT_BITS){1'b0}}, out_step_reg, out_cmd_valid_reg, out_region_reg};
    assign m_tuser  = out_kind_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_reg[0]         <= tbhar_pkg::MINUS_RECT_RESET;
            rect_reg[1]         <= tbhar_pkg::PLUS_RECT_RESET;
            rect_reg[2]         <= tbhar_pkg::TRANSPORT_RECT_RESET;
            rect_reg[3]         <= tbhar_pkg::TAP_RECT_RESET;
            hold_delay_reg      <= tbhar_pkg::HOLD_DELAY_RESET;
            repeat_interval_reg <= tbhar_pkg::REPEAT_INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbhar_pkg::CFG_MINUS_RECT:      rect_reg[0] <= cfg_data;
                tbhar_pkg::CFG_PLUS_RECT:       rect_reg[1] <= cfg_data;
                tbhar_pkg::CFG_TRANSPORT_RECT:  rect_reg[2] <= cfg_data;
                tbhar_pkg::CFG_TAP_RECT:        rect_reg[3] <= cfg_data;
                tbhar_pkg::CFG_HOLD_DELAY:
                    hold_delay_reg <= cfg_data[tbhar_pkg::DELAY_BITS-1:0];
                tbhar_pkg::CFG_REPEAT_INTERVAL:
                    repeat_interval_reg <= cfg_data[tbhar_pkg::DELAY_BITS-1:0];
                default: ;  // unused index, dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_down_reg <= s_tdata[0];
            in_x_reg    <= s_tdata[X_LSB +: COORD_BITS];
            in_y_reg    <= s_tdata[Y_LSB +: COORD_BITS];
            in_time_reg <= s_tdata[T_LSB +: TIME_BITS];
        end
    end

    // button hit tests, one per rectangle
    for (genvar i = 0; i < tbhar_pkg::NUM_RECTS; i++)
    begin : g_hit
        tbhar_rect_hit #(
            .COORD_BITS (COORD_BITS)
        ) u_hit (
            .x    (in_x_reg),
            .y    (in_y_reg),
            .rect (rect_reg[i]),
            .hit  (hits[i])
        );
    end

    // minus wins over plus, plus over transport, transport over tap
    always_comb
    begin
        priority if (hits[0])
            hit_region = tbhar_pkg::REGION_MINUS;
        else if (hits[1])
            hit_region = tbhar_pkg::REGION_PLUS;
        else if (hits[2])
            hit_region = tbhar_pkg::REGION_TRANSPORT;
        else if (hits[3])
            hit_region = tbhar_pkg::REGION_TAP;
        else
            hit_region = tbhar_pkg::REGION_NONE;
    end

    // elapsed times wrap modulo the timestamp width
    assign since_press = in_time_reg - press_time_reg;
    assign since_fire  = in_time_reg - last_fire_time_reg;
    assign hold_delay_ext =
        {{(TIME_BITS - tbhar_pkg::DELAY_BITS){1'b0}}, hold_delay_reg};
    assign repeat_interval_ext =
        {{(TIME_BITS - tbhar_pkg::DELAY_BITS){1'b0}}, repeat_interval_reg};

    // only minus and plus repeat, and only on the button first pressed
    assign repeat_due = ((hit_region == tbhar_pkg::REGION_MINUS)
                      || (hit_region == tbhar_pkg::REGION_PLUS))
                     && (hit_region == held_region_reg)
                     && (since_press > hold_delay_ext)
                     && (since_fire > repeat_interval_ext);

    // state update and fire decision for the poll in the input register
    always_comb
    begin
        was_pressed_next    = was_pressed_reg;
        held_region_next    = held_region_reg;
        press_time_next     = press_time_reg;
        last_fire_time_next = last_fire_time_reg;
        out_region_next     = hit_region;
        fire                = 1'b0;

        priority if (!in_down_reg)
        begin
            // release: drop the held button, keep the timestamps
            was_pressed_next = 1'b0;
            held_region_next = tbhar_pkg::REGION_NONE;
            out_region_next  = tbhar_pkg::REGION_NONE;
        end
        else if (!was_pressed_reg)
        begin
            // fresh press latches even on empty screen area
            was_pressed_next    = 1'b1;
            held_region_next    = hit_region;
            press_time_next     = in_time_reg;
            last_fire_time_next = in_time_reg;
            fire                = 1'b1;
        end
        else if (repeat_due)
        begin
            last_fire_time_next = in_time_reg;
            fire                = 1'b1;
        end
        else
        begin
            fire = 1'b0;
        end
    end

    // command encoding for the region that fired
    always_comb
    begin
        out_cmd_valid_next = 1'b0;
        out_kind_next      = tbhar_pkg::KIND_NUDGE;
        out_step_next      = tbhar_pkg::STEP_NONE;
        if (fire)
        begin
            unique case (out_region_next)
                tbhar_pkg::REGION_MINUS:
                begin
                    out_cmd_valid_next = 1'b1;
                    out_step_next      = tbhar_pkg::STEP_DOWN;
                end
                tbhar_pkg::REGION_PLUS:
                begin
                    out_cmd_valid_next = 1'b1;
                    out_step_next      = tbhar_pkg::STEP_UP;
                end
                tbhar_pkg::REGION_TRANSPORT:
                begin
                    out_cmd_valid_next = 1'b1;
                    out_kind_next      = tbhar_pkg::KIND_TRANSPORT;
                end
                tbhar_pkg::REGION_TAP:
                begin
                    out_cmd_valid_next = 1'b1;
                    out_kind_next      = tbhar_pkg::KIND_TAP;
                end
                default: ;  // no button under the touch
            endcase
        end
    end

    // held-touch state moves with the poll into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg    <= 1'b0;
            held_region_reg    <= tbhar_pkg::REGION_NONE;
            press_time_reg     <= '0;
            last_fire_time_reg <= '0;
        end
        else if (advance)
        begin
            was_pressed_reg    <= was_pressed_next;
            held_region_reg    <= held_region_next;
            press_time_reg     <= press_time_next;
            last_fire_time_reg <= last_fire_time_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_region_reg    <= out_region_next;
            out_cmd_valid_reg <= out_cmd_valid_next;
            out_kind_reg      <= out_kind_next;
            out_step_reg      <= out_step_next;
        end
    end

endmodule

`default_nettype wire

### bench/tb_touch_button_hit_auto_repeat.sv
`timescale 1ns / 100ps

module tb_touch_button_hit_auto_repeat;

    localparam int COORD_W   = tbhar_pkg::COORD_BITS_DEFAULT;
    localparam int TIME_W    = tbhar_pkg::TIME_BITS_DEFAULT;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam int POLL_BITS = ((1 + 2*COORD_W + TIME_W + 7) / 8) * 8;

    // indexes past the register map, written to show they are ignored
    localparam tbhar_pkg::cfg_index_t CFG_SPARE_LOW  = 3'd6;
    localparam tbhar_pkg::cfg_index_t CFG_SPARE_HIGH = 3'd7;

    // where a generated touch lands: inside one of the button rectangles or anywhere
    localparam int AIM_MINUS     = 0;
    localparam int AIM_PLUS      = 1;
    localparam int AIM_TRANSPORT = 2;
    localparam int AIM_TAP       = 3;
    localparam int AIM_ANY       = 4;

    // long receiver hold-off, enough to fill both internal registers
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        logic               down;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TIME_W-1:0]  stamp;
    } poll_t;

    typedef struct {
        tbhar_pkg::region_t region;
        logic               command_valid;
        tbhar_pkg::kind_t   command_kind;
        tbhar_pkg::step_t   nudge_step;
    } hit_result_t;

    // button decoder with auto-repeat: own copy of registers and held-touch state,
    // plus the queue of results still owed by the block
    class hit_scoreboard;
        // minus, plus, transport, tap
        logic [tbhar_pkg::RECT_BITS-1:0]  rect_cfg [tbhar_pkg::NUM_RECTS];
        logic [tbhar_pkg::DELAY_BITS-1:0] hold_us;
        logic [tbhar_pkg::DELAY_BITS-1:0] interval_us;
        logic                  touching;
        tbhar_pkg::region_t    held;
        logic [TIME_W-1:0]     pressed_at;
        logic [TIME_W-1:0]     fired_at;
        hit_result_t           awaited [$];
        int                    errors;

        function new();
            rect_cfg[AIM_MINUS]     = tbhar_pkg::MINUS_RECT_RESET;
            rect_cfg[AIM_PLUS]      = tbhar_pkg::PLUS_RECT_RESET;
            rect_cfg[AIM_TRANSPORT] = tbhar_pkg::TRANSPORT_RECT_RESET;
            rect_cfg[AIM_TAP]       = tbhar_pkg::TAP_RECT_RESET;
            hold_us     = tbhar_pkg::HOLD_DELAY_RESET;
            interval_us = tbhar_pkg::REPEAT_INTERVAL_RESET;
            touching    = 1'b0;
            held        = tbhar_pkg::REGION_NONE;
            pressed_at  = '0;
            fired_at    = '0;
            errors      = 0;
        endfunction

        function void write_reg(tbhar_pkg::cfg_index_t idx,
                                logic [tbhar_pkg::RECT_BITS-1:0] value);
            case (idx)
                tbhar_pkg::CFG_MINUS_RECT:      rect_cfg[AIM_MINUS]     = value;
                tbhar_pkg::CFG_PLUS_RECT:       rect_cfg[AIM_PLUS]      = value;
                tbhar_pkg::CFG_TRANSPORT_RECT:  rect_cfg[AIM_TRANSPORT] = value;
                tbhar_pkg::CFG_TAP_RECT:        rect_cfg[AIM_TAP]       = value;
                tbhar_pkg::CFG_HOLD_DELAY:
                    hold_us = value[tbhar_pkg::DELAY_BITS-1:0];
                tbhar_pkg::CFG_REPEAT_INTERVAL:
                    interval_us = value[tbhar_pkg::DELAY_BITS-1:0];
                default: ;
            endcase
        endfunction

        // right and bottom edges are formed without wrap, so big rectangles clip
        function bit covers_point(logic [tbhar_pkg::RECT_BITS-1:0] r,
                                  logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            int rx, ry, rw, rh, px, py;
            rx = int'(r[3*COORD_W +: COORD_W]);
            ry = int'(r[2*COORD_W +: COORD_W]);
            rw = int'(r[COORD_W +: COORD_W]);
            rh = int'(r[0 +: COORD_W]);
            px = int'(x);
            py = int'(y);
            return px >= rx && py >= ry && px < rx + rw && py < ry + rh;
        endfunction

        function tbhar_pkg::region_t locate_touch(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
            if (covers_point(rect_cfg[AIM_MINUS], x, y))
                return tbhar_pkg::REGION_MINUS;
            if (covers_point(rect_cfg[AIM_PLUS], x, y))
                return tbhar_pkg::REGION_PLUS;
            if (covers_point(rect_cfg[AIM_TRANSPORT], x, y))
                return tbhar_pkg::REGION_TRANSPORT;
            if (covers_point(rect_cfg[AIM_TAP], x, y))
                return tbhar_pkg::REGION_TAP;
            return tbhar_pkg::REGION_NONE;
        endfunction

        function void note_poll(poll_t p);
            hit_result_t        r;
            tbhar_pkg::region_t hit;
            logic               fire;
            logic [TIME_W-1:0]  since_press;
            logic [TIME_W-1:0]  since_fire;
            hit  = tbhar_pkg::REGION_NONE;
            fire = 1'b0;
            if (!p.down) begin
                touching = 1'b0;
                held     = tbhar_pkg::REGION_NONE;
            end
            else begin
                hit = locate_touch(p.x, p.y);
                since_press = p.stamp - pressed_at;
                since_fire  = p.stamp - fired_at;
                if (!touching) begin
                    touching   = 1'b1;
                    held       = hit;
                    pressed_at = p.stamp;
                    fired_at   = p.stamp;
                    fire       = 1'b1;
                end
                else if ((hit == tbhar_pkg::REGION_MINUS || hit == tbhar_pkg::REGION_PLUS)
                         && hit == held
                         && since_press > TIME_W'(hold_us)
                         && since_fire > TIME_W'(interval_us)) begin
                    fired_at = p.stamp;
                    fire     = 1'b1;
                end
            end
            r.region        = hit;
            r.command_valid = 1'b0;
            r.command_kind  = tbhar_pkg::KIND_NUDGE;
            r.nudge_step    = tbhar_pkg::STEP_NONE;
            if (fire) begin
                case (hit)
                    tbhar_pkg::REGION_MINUS:
                    begin
                        r.command_valid = 1'b1;
                        r.nudge_step    = tbhar_pkg::STEP_DOWN;
                    end
                    tbhar_pkg::REGION_PLUS:
                    begin
                        r.command_valid = 1'b1;
                        r.nudge_step    = tbhar_pkg::STEP_UP;
                    end
                    tbhar_pkg::REGION_TRANSPORT:
                    begin
                        r.command_valid = 1'b1;
                        r.command_kind  = tbhar_pkg::KIND_TRANSPORT;
                    end
                    tbhar_pkg::REGION_TAP:
                    begin
                        r.command_valid = 1'b1;
                        r.command_kind  = tbhar_pkg::KIND_TAP;
                    end
                    default: ;
                endcase
            end
            awaited.push_back(r);
        endfunction

        function void check_result(hit_result_t got);
            hit_result_t want;
            if (awaited.size() == 0) begin
                $error("result with no poll outstanding: region %0d", got.region);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.region !== want.region) begin
                $error("region: expected %0d, got %0d", want.region, got.region);
                errors++;
            end
            if (got.command_valid !== want.command_valid) begin
                $error("command_valid: expected %0d, got %0d",
                       want.command_valid, got.command_valid);
                errors++;
            end
            if (got.command_kind !== want.command_kind) begin
                $error("command_kind: expected %0d, got %0d",
                       want.command_kind, got.command_kind);
                errors++;
            end
            if (got.nudge_step !== want.nudge_step) begin
                $error("nudge_step: expected %0d, got %0d",
                       $signed(want.nudge_step), $signed(got.nudge_step));
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // touch_down, touch_x, touch_y, time_us (zero padding above)
    logic [POLL_BITS-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // region, command_valid, nudge_step (zero padding above)
    logic [7:0]            m_tdata;
    // command_kind
    logic [tbhar_pkg::KIND_BITS-1:0] m_tuser;
    logic                            cfg_we;
    tbhar_pkg::cfg_index_t           cfg_index;
    logic [tbhar_pkg::RECT_BITS-1:0] cfg_data;

    hit_scoreboard         sb;
    logic [TIME_W-1:0]     clock_us;       // running timestamp for well-formed sessions
    bit                    stall_output;   // asks the receiver for one long hold-off

    touch_button_hit_auto_repeat DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // idle cycles before the next transaction; zero most of the time so that
    // back-to-back stretches appear alongside the gaps
    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
    endfunction

    function automatic logic [TIME_W-1:0] random_stamp();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[TIME_W-1:0];
    endfunction

    function automatic logic [tbhar_pkg::RECT_BITS-1:0] make_rect(int x, int y, int w, int h);
        return {x[COORD_W-1:0], y[COORD_W-1:0], w[COORD_W-1:0], h[COORD_W-1:0]};
    endfunction

    function automatic logic [tbhar_pkg::RECT_BITS-1:0] small_rect();
        return make_rect($urandom_range(0, 700), $urandom_range(0, 700),
                         $urandom_range(1, 700), $urandom_range(1, 700));
    endfunction

    function automatic logic [tbhar_pkg::RECT_BITS-1:0] random_rect();
        return tbhar_pkg::RECT_BITS'({$urandom, $urandom});
    endfunction

    // input side: valid stays high across back-to-back transactions, the
    // poll goes to the predictor at the edge where it is taken
    task automatic send_poll(input poll_t p);
        int                   gap;
        logic [POLL_BITS-1:0] word;
        gap  = draw_gap();
        word = '0;
        word[0]                       = p.down;
        word[1 +: COORD_W]            = p.x;
        word[1 + COORD_W +: COORD_W]  = p.y;
        word[1 + 2*COORD_W +: TIME_W] = p.stamp;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_poll(p);
    endtask

    // pick a point inside the chosen button, clipped to the panel; an empty
    // rectangle or AIM_ANY gives a point anywhere
    task automatic aim(input int target, output logic [COORD_W-1:0] x,
                       output logic [COORD_W-1:0] y);
        logic [tbhar_pkg::RECT_BITS-1:0] r;
        int rx, ry, rw, rh, x_top, y_top;
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
        if (target < tbhar_pkg::NUM_RECTS) begin
            r  = sb.rect_cfg[target];
            rx = int'(r[3*COORD_W +: COORD_W]);
            ry = int'(r[2*COORD_W +: COORD_W]);
            rw = int'(r[COORD_W +: COORD_W]);
            rh = int'(r[0 +: COORD_W]);
            if (rw != 0 && rh != 0) begin
                x_top = (rx + rw - 1 > COORD_MAX) ? COORD_MAX : rx + rw - 1;
                y_top = (ry + rh - 1 > COORD_MAX) ? COORD_MAX : ry + rh - 1;
                x = COORD_W'($urandom_range(x_top, rx));
                y = COORD_W'($urandom_range(y_top, ry));
            end
        end
    endtask

    task automatic touch(input logic down, input int target, input logic [TIME_W-1:0] stamp);
        poll_t              p;
        logic [COORD_W-1:0] px, py;
        aim(target, px, py);
        p.down  = down;
        p.x     = px;
        p.y     = py;
        p.stamp = stamp;
        send_poll(p);
    endtask

    // time steps scaled to the current delays so that both sides of each
    // threshold are reached, with the odd jump across the whole range
    task automatic advance_clock();
        case ($urandom_range(0, 9))
            0: ;
            1, 2, 3, 4: clock_us += $urandom_range(0, 2 * sb.interval_us + 2);
            5, 6, 7:    clock_us += $urandom_range(0, sb.hold_us + sb.interval_us + 2);
            8:          clock_us += $urandom;
            default:    clock_us = random_stamp();
        endcase
    endtask

    // mostly release, press, hold sequences; the rest raw noise polls
    task automatic play_random(input int count);
        int    sent, target, holds;
        poll_t p;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 6) == 0) begin
                p.down  = 1'($urandom);
                p.x     = COORD_W'($urandom);
                p.y     = COORD_W'($urandom);
                p.stamp = random_stamp();
                send_poll(p);
                sent++;
            end
            else begin
                advance_clock();
                touch(1'b0, AIM_ANY, clock_us);
                target = $urandom_range(0, AIM_ANY);
                advance_clock();
                touch(1'b1, target, clock_us);
                holds = $urandom_range(0, 12);
                sent += 2 + holds;
                repeat (holds) begin
                    advance_clock();
                    case ($urandom_range(0, 9))
                        0:       touch(1'b1, $urandom_range(0, tbhar_pkg::NUM_RECTS - 1),
                                       clock_us);
                        1:       touch(1'b1, AIM_ANY, clock_us);
                        default: touch(1'b1, target, clock_us);
                    endcase
                end
            end
        end
    endtask

    task automatic write_reg(input tbhar_pkg::cfg_index_t idx,
                             input logic [tbhar_pkg::RECT_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // stop offering polls and let every owed result come out, with a bound;
    // a final wait covers the two-stage pipeline
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // hand-picked polls under the power-on settings: field extremes, every
    // button, hold threshold and repeat interval met exactly and by one,
    // sliding onto another button, and a hold across the timestamp wrap
    task automatic directed_polls();
        logic [TIME_W-1:0] t0, tw, hd, iv;
        t0 = TIME_W'(1000);
        tw = '1 - TIME_W'(15);
        hd = TIME_W'(sb.hold_us);
        iv = TIME_W'(sb.interval_us);
        send_poll('{down: 1'b0, x: '0, y: '0, stamp: '0});
        send_poll('{down: 1'b0, x: '1, y: '1, stamp: '1});
        send_poll('{down: 1'b1, x: '0, y: '0, stamp: '0});
        send_poll('{down: 1'b1, x: '1, y: '1, stamp: '1});
        touch(1'b0, AIM_ANY, TIME_W'(5));
        touch(1'b1, AIM_MINUS, t0);
        touch(1'b1, AIM_MINUS, t0 + hd);
        touch(1'b1, AIM_MINUS, t0 + hd + 1);
        touch(1'b1, AIM_MINUS, t0 + hd + 1 + iv);
        touch(1'b1, AIM_MINUS, t0 + hd + 2 + iv);
        touch(1'b1, AIM_PLUS, t0 + 3 * hd);
        touch(1'b1, AIM_MINUS, t0 + 4 * hd);
        touch(1'b0, AIM_MINUS, t0 + 4 * hd);
        touch(1'b1, AIM_PLUS, tw);
        touch(1'b1, AIM_PLUS, tw + hd + 1);
        touch(1'b1, AIM_PLUS, tw + hd + 2);
        touch(1'b0, AIM_ANY, tw + hd + 3);
        touch(1'b1, AIM_TRANSPORT, TIME_W'(1));
        touch(1'b1, AIM_TRANSPORT, 1 + 2 * hd);
        touch(1'b0, AIM_ANY, 2 + 2 * hd);
        touch(1'b1, AIM_TAP, TIME_W'(3));
        touch(1'b1, AIM_TAP, 3 + 2 * hd);
        touch(1'b0, AIM_ANY, 4 + 2 * hd);
        clock_us = 4 + 2 * hd;
    endtask

    // receiver: one stall draw per result, plus the long hold-off on request
    // while the sender keeps offering, so the block backs up onto its input
    initial begin
        int          gap;
        hit_result_t got;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            gap = draw_gap();
            if (stall_output) begin
                gap          = HOLD_OFF_CYCLES;
                stall_output = 1'b0;
            end
            @(negedge clk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got.region        = m_tdata[0 +: tbhar_pkg::REGION_BITS];
            got.command_valid = m_tdata[tbhar_pkg::REGION_BITS];
            got.nudge_step    = m_tdata[tbhar_pkg::REGION_BITS + 1 +: tbhar_pkg::STEP_BITS];
            got.command_kind  = m_tuser;
            sb.check_result(got);
        end
    end

    // run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("touch_button_hit_auto_repeat test failed");
        $finish;
    end

    initial begin
        sb           = new();
        stall_output = 1'b0;
        clock_us     = '0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = tbhar_pkg::CFG_MINUS_RECT;
        cfg_data     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // power-on settings, with the long receiver hold-off early on
        directed_polls();
        stall_output = 1'b1;
        play_random(250);
        drain();

        // small overlapping buttons so priority matters, short delays
        write_reg(tbhar_pkg::CFG_MINUS_RECT, small_rect());
        write_reg(tbhar_pkg::CFG_PLUS_RECT, small_rect());
        write_reg(tbhar_pkg::CFG_TRANSPORT_RECT, small_rect());
        write_reg(tbhar_pkg::CFG_TAP_RECT, small_rect());
        write_reg(tbhar_pkg::CFG_HOLD_DELAY,
                  tbhar_pkg::RECT_BITS'($urandom_range(0, 5000)));
        write_reg(tbhar_pkg::CFG_REPEAT_INTERVAL,
                  tbhar_pkg::RECT_BITS'($urandom_range(0, 3000)));
        play_random(250);
        drain();

        // extremes: clipped corner button, all of the panel but its last row and column,
        // empty buttons, zero delays, and writes to indexes outside the map
        write_reg(tbhar_pkg::CFG_MINUS_RECT, '1);
        write_reg(tbhar_pkg::CFG_PLUS_RECT, make_rect(0, 0, COORD_MAX, COORD_MAX));
        write_reg(tbhar_pkg::CFG_TRANSPORT_RECT, make_rect(100, 100, 0, 200));
        write_reg(tbhar_pkg::CFG_TAP_RECT, '0);
        write_reg(tbhar_pkg::CFG_HOLD_DELAY, '0);
        write_reg(tbhar_pkg::CFG_REPEAT_INTERVAL, '0);
        write_reg(CFG_SPARE_LOW, random_rect());
        write_reg(CFG_SPARE_HIGH, '1);
        play_random(250);
        drain();

        // fully random rectangles, longest delays, second long hold-off
        write_reg(tbhar_pkg::CFG_MINUS_RECT, random_rect());
        write_reg(tbhar_pkg::CFG_PLUS_RECT, random_rect());
        write_reg(tbhar_pkg::CFG_TRANSPORT_RECT, random_rect());
        write_reg(tbhar_pkg::CFG_TAP_RECT, random_rect());
        write_reg(tbhar_pkg::CFG_HOLD_DELAY,
                  tbhar_pkg::RECT_BITS'({tbhar_pkg::DELAY_BITS{1'b1}}));
        write_reg(tbhar_pkg::CFG_REPEAT_INTERVAL,
                  tbhar_pkg::RECT_BITS'({tbhar_pkg::DELAY_BITS{1'b1}}));
        stall_output = 1'b1;
        play_random(250);
        drain();

        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
        end
        if (sb.pending() == 0 && sb.errors == 0) begin
            $display("touch_button_hit_auto_repeat test passed");
        end
        else begin
            $display("touch_button_hit_auto_repeat test failed");
        end
        $finish;
    end

endmodule
